@@ sv/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master engine package
// Shared transfer types, command codes and the SDA data-phase helper.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Command codes, as carried on the op field
    typedef enum logic [2:0] {
        CMD_IDLE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_WRITE     = 3'd2,
        CMD_READ_ACK  = 3'd3,
        CMD_READ_NACK = 3'd4,
        CMD_STOP      = 3'd5
    } cmd_t;

    // Eight data bits plus the ACK bit
    localparam logic [3:0] BIT_COUNT = 4'd9;
    localparam logic [3:0] DATA_BITS = 4'd8;

    // Reset value of the phase length register
    localparam int unsigned PHASE_TICKS_DEFAULT = 5;

    // Phase positions inside a command
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // Input transfer: one tick, optional command, sampled SDA
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       sda_in;
    } in_item_t;

    // Result transfer: line drives and status after the tick
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       ack_seen;
        logic [7:0] read_byte;
    } out_item_t;

    // SDA level for the data phase of a bit (SCL low)
    function automatic logic data_phase_sda(cmd_t cmd, logic [3:0] bit_idx, logic msb);
        logic level;
        if (cmd == CMD_WRITE)
            level = (bit_idx < DATA_BITS) ? msb : 1'b1;
        else if (bit_idx < DATA_BITS)
            level = 1'b1;
        else
            level = (cmd == CMD_READ_ACK) ? 1'b0 : 1'b1;
        return level;
    endfunction

endpackage

@@ sv/i2cm_engine.sv @@
// ----------------------------------------------------------------------------
// I2C master tick engine
// Holds the bus state and advances it by one tick per enabled cycle.
// ----------------------------------------------------------------------------
module i2cm_engine
    import i2cm_pkg::*;
#(
    parameter int TICK_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  in_item_t              item,
    input  logic [TICK_WIDTH-1:0] phase_ticks,
    output out_item_t             result
);

    cmd_t                  cmd_reg,   cmd_next;
    logic [1:0]            phase_reg, phase_next;
    logic [TICK_WIDTH-1:0] tick_reg,  tick_next;
    logic [3:0]            bit_reg,   bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  ack_reg,   ack_next;
    logic [7:0]            read_reg,  read_next;
    logic                  scl_reg,   scl_next;
    logic                  sda_reg,   sda_next;
    logic                  done;
    logic                  op_valid;

    // Codes 1..5 launch a command; others are no command
    assign op_valid = (item.op >= CMD_START) && (item.op <= CMD_STOP);

    // One tick of the bus sequencer
    always_comb
    begin
        logic [TICK_WIDTH-1:0] tick_inc;
        logic [TICK_WIDTH-1:0] limit;
        logic                  finish;

        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        ack_next   = ack_reg;
        read_next  = read_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        done       = 1'b0;
        finish     = 1'b0;
        tick_inc   = '0;
        limit      = (phase_ticks == '0) ? TICK_WIDTH'(1) : phase_ticks;

        // Launch: the launching tick is the first tick of phase 0
        if (cmd_reg == CMD_IDLE && op_valid)
        begin
            cmd_next   = cmd_t'(item.op);
            phase_next = PHASE_0;
            tick_next  = '0;
            bit_next   = '0;
            unique case (cmd_next)
                CMD_START:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                CMD_STOP:
                begin
                    sda_next = 1'b0;
                end
                default:
                begin
                    shift_next = (cmd_next == CMD_WRITE) ? item.data : 8'h00;
                    sda_next   = data_phase_sda(cmd_next, 4'd0, shift_next[7]);
                end
            endcase
        end

        // Phase timer and end-of-phase actions
        if (cmd_next != CMD_IDLE)
        begin
            tick_inc  = tick_next + TICK_WIDTH'(1);
            tick_next = tick_inc;
            if (tick_inc >= limit || tick_inc == '0)
            begin
                tick_next = '0;
                unique case (cmd_next)
                    CMD_START:
                    begin
                        if (phase_next == PHASE_0)
                        begin
                            sda_next   = 1'b0;
                            phase_next = PHASE_1;
                        end
                        else if (phase_next == PHASE_1)
                        begin
                            scl_next   = 1'b0;
                            phase_next = PHASE_2;
                        end
                        else
                        begin
                            sda_next = 1'b1;
                            finish   = 1'b1;
                        end
                    end
                    CMD_STOP:
                    begin
                        if (phase_next == PHASE_0)
                        begin
                            scl_next   = 1'b1;
                            phase_next = PHASE_1;
                        end
                        else if (phase_next == PHASE_1)
                        begin
                            sda_next   = 1'b1;
                            phase_next = PHASE_2;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        // Write or read: data phase then SCL-high phase
                        if (phase_next == PHASE_0)
                        begin
                            scl_next   = 1'b1;
                            phase_next = PHASE_1;
                        end
                        else
                        begin
                            if (cmd_next == CMD_WRITE)
                            begin
                                if (bit_next < DATA_BITS)
                                    shift_next = {shift_next[6:0], 1'b0};
                                else
                                    ack_next = ~item.sda_in;
                            end
                            else if (bit_next < DATA_BITS)
                            begin
                                shift_next = {shift_next[6:0], item.sda_in};
                            end
                            scl_next = 1'b0;
                            bit_next = bit_next + 4'd1;
                            if (bit_next >= BIT_COUNT)
                            begin
                                if (cmd_next != CMD_WRITE)
                                    read_next = shift_next;
                                finish = 1'b1;
                            end
                            else
                            begin
                                phase_next = PHASE_0;
                                sda_next   = data_phase_sda(cmd_next, bit_next,
                                                            shift_next[7]);
                            end
                        end
                    end
                endcase
            end
        end

        // Command complete
        if (finish)
        begin
            cmd_next   = CMD_IDLE;
            phase_next = PHASE_0;
            bit_next   = '0;
            done       = 1'b1;
        end
    end

    // Result of this tick
    always_comb
    begin
        result.scl_out   = scl_next;
        result.sda_out   = sda_next;
        result.busy_res  = (cmd_next != CMD_IDLE);
        result.done_res  = done;
        result.ack_seen  = ack_next;
        result.read_byte = read_next;
    end

    // Bus state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_IDLE;
            phase_reg <= PHASE_0;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            ack_reg   <= 1'b0;
            read_reg  <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
        end
        else if (en)
        begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            ack_reg   <= ack_next;
            read_reg  <= read_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
        end
    end

endmodule

@@ sv/i2c_master_bit_byte_engine.sv @@
// ----------------------------------------------------------------------------
// I2C master bit/byte engine
// Tick-driven start/write/read/stop sequencer with registered transfers.
// ----------------------------------------------------------------------------
// Each input transfer is one timing tick: it may carry a command (op) and the
// byte to send, and always carries the sampled SDA level. Each input transfer
// yields exactly one result transfer with the SCL/SDA drives (1 = released),
// busy, a one-tick done pulse, the last ACK seen and the last byte read.
// Commands arriving while busy are ignored.
// cfg_wen/cfg_wdata load the phase length (ticks per bus phase, 0 acts as 1);
// write it only while no transfer is in flight.
// An input transfer passes the input register, the tick logic and the result
// register before its result is valid on out_*. One transfer is taken per
// cycle while out_stall is low; the phase timer compare and increment set
// the path. Reset releases both lines, clears the engine to idle, empties
// both registers and sets the phase length to 5. When out_stall is high the
// result holds, the input register holds one more tick, and in_stall rises
// only when both are full.
// ----------------------------------------------------------------------------
module i2c_master_bit_byte_engine
    import i2cm_pkg::*;
#(
    parameter int TICK_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [TICK_WIDTH-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item
);

    logic [TICK_WIDTH-1:0] phase_ticks_reg;
    logic                  in_valid_reg;
    in_item_t              in_item_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;
    out_item_t             result;
    logic                  advance;

    // A tick is processed when its result has somewhere to go
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // Phase length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_ticks_reg <= TICK_WIDTH'(PHASE_TICKS_DEFAULT);
        else if (cfg_wen)
            phase_ticks_reg <= cfg_wdata;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_item;
    end

    // Tick logic and bus state
    i2cm_engine #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .item        (in_item_reg),
        .phase_ticks (phase_ticks_reg),
        .result      (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ sv/i2cm_checker.sv @@
// ----------------------------------------------------------------------------
// I2C master engine port checker
// Port-level checks on the transfer channels, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    // Held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // Input side only backs up behind a full, stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // A finishing tick leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.done_res |-> !out_item.busy_res)
        else $error("done with busy still set");

    // Every command spans several ticks, so done never repeats back to back
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_item.done_res
        |=> !(out_valid && !out_stall && out_item.done_res))
        else $error("done pulse on consecutive results");

endmodule

bind i2c_master_bit_byte_engine i2cm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
